// ===== hw/rtl/escaped_length_frame_receiver_core_assert.svh =====
// Assertion macros for the deframer RTL.
// The using module must have clk and rst_n in scope.
`ifndef ESCAPED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH
`define ESCAPED_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define ELFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication.
`define ELFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/elfr_pkg.sv =====
package elfr_pkg;

    localparam int COUNT_WIDTH = 13;   // raw/escape counters, raw_byte_count
    localparam int CFG_WIDTH   = 13;   // max_frame_bytes
    localparam int LEN_WIDTH   = 16;
    localparam int CMP_WIDTH   = 18;   // holds length + escapes + trailer

    localparam logic [7:0]           SYNC_BYTE     = 8'hFD;
    localparam logic [7:0]           ESC_BYTE      = 8'hFC;
    localparam logic [7:0]           ESC_FLAG      = 8'h80;
    localparam logic [2:0]           TRAILER_BYTES = 3'd5;
    localparam logic [CFG_WIDTH-1:0] MAX_FRAME_RST = CFG_WIDTH'(80);

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SYNC     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } elfr_err_t;

    typedef struct packed {
        logic [7:0]             byte_out;
        logic                   accepted;
        logic                   frame_first;
        logic                   frame_last;
        elfr_err_t              error_code;
        logic [LEN_WIDTH-1:0]   message_length;
        logic [COUNT_WIDTH-1:0] raw_byte_count;
    } elfr_result_t;

endpackage

// ===== hw/rtl/elfr_if.sv =====
interface elfr_in_if;
    import elfr_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface elfr_out_if;
    import elfr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [7:0]             byte_out;
    logic                   accepted;
    logic                   frame_first;
    logic                   frame_last;
    logic [1:0]             error_code;
    logic [LEN_WIDTH-1:0]   message_length;
    logic [COUNT_WIDTH-1:0] raw_byte_count;

    modport source (output valid, output byte_out, output accepted, output frame_first,
                    output frame_last, output error_code, output message_length,
                    output raw_byte_count, input ready);
    modport sink   (input valid, input byte_out, input accepted, input frame_first,
                    input frame_last, input error_code, input message_length,
                    input raw_byte_count, output ready);
endinterface

// ===== hw/rtl/elfr_deframe.sv =====
// Frame state and per-word decode; state advances on step.
module elfr_deframe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [7:0]                       byte_in,
    input  logic [elfr_pkg::CFG_WIDTH-1:0]   max_frame_bytes,
    output elfr_pkg::elfr_result_t           result
);
    import elfr_pkg::*;

    logic                   in_frame_reg,       in_frame_next;
    logic [COUNT_WIDTH-1:0] raw_count_reg,      raw_count_next;
    logic [COUNT_WIDTH-1:0] escape_count_reg,   escape_count_next;
    logic                   escape_pending_reg, escape_pending_next;
    logic [LEN_WIDTH-1:0]   length_value_reg,   length_value_next;
    logic                   length_known_reg,   length_known_next;

    logic                   is_sync;
    logic                   is_esc;
    logic [COUNT_WIDTH-1:0] raw_inc;
    logic [COUNT_WIDTH-1:0] pos;
    logic [7:0]             len_byte;
    logic [CMP_WIDTH-1:0]   end_count;
    logic                   done;
    logic                   cut;

    assign is_sync  = (byte_in == SYNC_BYTE);
    assign is_esc   = (byte_in == ESC_BYTE);
    assign raw_inc  = raw_count_reg + COUNT_WIDTH'(1);
    assign pos      = raw_inc - escape_count_reg;   // escapes skip positions
    assign len_byte = byte_in | (escape_pending_reg ? ESC_FLAG : 8'h00);

    always_comb
    begin
        in_frame_next       = in_frame_reg;
        raw_count_next      = raw_count_reg;
        escape_count_next   = escape_count_reg;
        escape_pending_next = escape_pending_reg;
        length_value_next   = length_value_reg;
        length_known_next   = length_known_reg;

        end_count = '0;
        done      = 1'b0;
        cut       = 1'b0;

        result                = '0;
        result.byte_out       = byte_in;
        result.error_code     = ERR_NONE;

        if (!is_sync && !in_frame_reg)
        begin
            result.error_code = ERR_SYNC;
        end
        else
        begin
            if (is_sync)
            begin
                raw_count_next      = COUNT_WIDTH'(1);
                escape_count_next   = '0;
                escape_pending_next = 1'b0;
                length_value_next   = '0;
                length_known_next   = 1'b0;
            end
            else
            begin
                raw_count_next = raw_inc;
                if (is_esc)
                begin
                    escape_count_next   = escape_count_reg + COUNT_WIDTH'(1);
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    escape_pending_next = 1'b0;
                    if (!length_known_reg)
                    begin
                        if (pos == COUNT_WIDTH'(2))
                        begin
                            length_value_next = {len_byte, 8'h00};
                        end
                        else if (pos == COUNT_WIDTH'(3))
                        begin
                            length_value_next = length_value_reg | {8'h00, len_byte};
                            length_known_next = 1'b1;
                        end
                    end
                end
            end

            end_count = CMP_WIDTH'(length_value_next) + CMP_WIDTH'(escape_count_next)
                      + CMP_WIDTH'(TRAILER_BYTES);
            done = !is_sync && length_known_next
                && (CMP_WIDTH'(raw_count_next) >= end_count);
            // cap is min(max_frame_bytes, all-ones count)
            cut  = (CMP_WIDTH'(raw_count_next) >= CMP_WIDTH'(max_frame_bytes))
                || (&raw_count_next);

            in_frame_next         = !(done || cut);
            result.accepted       = 1'b1;
            result.frame_first    = is_sync;
            result.frame_last     = done || cut;
            result.error_code     = (!done && cut) ? ERR_OVERFLOW : ERR_NONE;
            result.message_length = length_known_next ? length_value_next : '0;
            result.raw_byte_count = raw_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            raw_count_reg      <= '0;
            escape_count_reg   <= '0;
            escape_pending_reg <= 1'b0;
            length_value_reg   <= '0;
            length_known_reg   <= 1'b0;
        end
        else if (step)
        begin
            in_frame_reg       <= in_frame_next;
            raw_count_reg      <= raw_count_next;
            escape_count_reg   <= escape_count_next;
            escape_pending_reg <= escape_pending_next;
            length_value_reg   <= length_value_next;
            length_known_reg   <= length_known_next;
        end
    end

endmodule

// ===== hw/rtl/escaped_length_frame_receiver_core.sv =====
// Deframer for a serial byte stream: 0xFD opens (or reopens) a frame, 0xFC
// inside a frame is an escape that is counted and sets bit 7 of a following
// length byte, and the two length bytes (big-endian) set where the frame
// ends: raw count = length + escapes + 5. A frame that reaches
// max_frame_bytes raw bytes first is cut with an overflow code. Every input
// word gives exactly one result word, echoing the byte with its flags.
// Rate: one word per cycle sustained while neither side stalls. The input
// register takes the word; when the result register is free or draining,
// the decode and the frame state update land in the result register. The
// only loop is the frame state register, updated once per word. Both sides
// may stall freely; one more input word is still taken while a result waits.
// max_frame_bytes is written through cfg_wr_en/cfg_wr_data; the user must
// write it only when idle, and the block itself does not enforce this.
module escaped_length_frame_receiver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    elfr_in_if.sink                        serial,
    elfr_out_if.source                     result,
    input  logic                           cfg_wr_en,
    input  logic [elfr_pkg::CFG_WIDTH-1:0] cfg_wr_data
);
    import elfr_pkg::*;

    `include "escaped_length_frame_receiver_core_assert.svh"

    // config register
    logic [CFG_WIDTH-1:0] max_frame_bytes_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic         out_valid_reg, out_valid_next;
    elfr_result_t out_res_reg;
    elfr_result_t step_res;

    logic advance;   // result register free or draining this cycle
    logic step;      // input word moves into the result register

    assign advance      = !out_valid_reg || result.ready;
    assign step         = in_valid_reg && advance;
    assign serial.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (serial.valid && serial.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    elfr_deframe u_deframe (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .byte_in         (in_byte_reg),
        .max_frame_bytes (max_frame_bytes_reg),
        .result          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg <= MAX_FRAME_RST;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_frame_bytes_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (serial.valid && serial.ready)
        begin
            in_byte_reg <= serial.byte_in;
        end
        if (step)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.byte_out       = out_res_reg.byte_out;
    assign result.accepted       = out_res_reg.accepted;
    assign result.frame_first    = out_res_reg.frame_first;
    assign result.frame_last     = out_res_reg.frame_last;
    assign result.error_code     = out_res_reg.error_code;
    assign result.message_length = out_res_reg.message_length;
    assign result.raw_byte_count = out_res_reg.raw_byte_count;

    // discarded words carry the sync error and no frame data
    `ELFR_ASSERT_NOW(a_discard_fields, out_valid_reg && !out_res_reg.accepted, out_res_reg.error_code == ERR_SYNC && out_res_reg.raw_byte_count == '0 && !out_res_reg.frame_last)
    // frame opener always counts as raw byte one
    `ELFR_ASSERT_NOW(a_first_count, out_valid_reg && out_res_reg.frame_first, out_res_reg.accepted && out_res_reg.raw_byte_count == COUNT_WIDTH'(1))
    // an overflow cut always closes the frame
    `ELFR_ASSERT_NOW(a_cut_closes, out_valid_reg && out_res_reg.error_code == ERR_OVERFLOW, out_res_reg.frame_last && out_res_reg.accepted)
    // a held input word is not dropped while the result side stalls
    `ELFR_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance, in_valid_reg)

endmodule

// ===== tb/sv/escaped_length_frame_receiver_core_tb.sv =====
`timescale 1ns / 100ps

module escaped_length_frame_receiver_core_tb;
    import elfr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_PERCENT = 9;
    localparam int RANDOM_WORDS  = 1200;   // framed words in the random part
    localparam int PHASE_WORDS   = 250;    // framed words per register setting
    localparam int LONG_CAP      = 300;    // long frames only at or below this limit
    localparam int TAIL_CYCLES   = 10;     // tail after the last owed result, leave margin

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_WIDTH-1:0] cfg_wr_data;

    elfr_in_if  serial_if ();
    elfr_out_if result_if ();

    escaped_length_frame_receiver_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .serial      (serial_if),
        .result      (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Deframer state as the block should hold it, plus the register copy.
    bit                     frame_open     = 1'b0;
    logic [COUNT_WIDTH-1:0] frame_raw      = '0;
    logic [COUNT_WIDTH-1:0] frame_escapes  = '0;
    bit                     escape_armed   = 1'b0;
    logic [LEN_WIDTH-1:0]   frame_length   = '0;
    bit                     length_seen    = 1'b0;
    logic [CFG_WIDTH-1:0]   max_frame_q    = MAX_FRAME_RST;

    // Result words still owed by the block, oldest first.
    elfr_result_t awaited_results [$];

    int mismatch_count = 0;
    int framed_words   = 0;    // words predicted as belonging to a frame
    bit source_stalls  = 1'b1;
    bit sink_stalls    = 1'b1;

    always #CLK_HALF clk = ~clk;

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("escaped_length_frame_receiver_core_tb: FAIL");
        $finish;
    end

    // Works out the result word for one received byte and moves the state on.
    function automatic elfr_result_t deframe_byte(input logic [7:0] rx);
        elfr_result_t           word;
        logic [7:0]             merged;
        logic [COUNT_WIDTH-1:0] position;
        word          = '0;
        word.byte_out = rx;
        // Stray byte with no frame open: flagged, state left alone.
        if (rx != SYNC_BYTE && !frame_open)
        begin
            word.error_code = ERR_SYNC;
            return word;
        end
        word.accepted = 1'b1;
        if (rx == SYNC_BYTE)
        begin
            // Opens a frame, or silently restarts the one in progress.
            frame_open       = 1'b1;
            frame_raw        = COUNT_WIDTH'(1);
            frame_escapes    = '0;
            escape_armed     = 1'b0;
            frame_length     = '0;
            length_seen      = 1'b0;
            word.frame_first = 1'b1;
        end
        else
        begin
            frame_raw++;
            if (rx == ESC_BYTE)
            begin
                frame_escapes++;
                escape_armed = 1'b1;
            end
            else
            begin
                // Escapes never take a position; the sync byte is position 1.
                merged       = rx | (escape_armed ? ESC_FLAG : 8'h00);
                position     = frame_raw - frame_escapes;
                escape_armed = 1'b0;
                if (!length_seen)
                begin
                    if (position == COUNT_WIDTH'(2))
                        frame_length = {merged, 8'h00};
                    else if (position == COUNT_WIDTH'(3))
                    begin
                        frame_length = frame_length | {8'h00, merged};
                        length_seen  = 1'b1;
                    end
                end
            end
        end
        // Completion beats the cut when both land on the same byte. The
        // register is 13 bits, so it never exceeds the counter ceiling.
        if (!word.frame_first && length_seen &&
            CMP_WIDTH'(frame_raw) >= CMP_WIDTH'(frame_length) + CMP_WIDTH'(frame_escapes)
                                     + CMP_WIDTH'(TRAILER_BYTES))
        begin
            word.frame_last = 1'b1;
            frame_open      = 1'b0;
        end
        else if (frame_raw >= max_frame_q)
        begin
            word.frame_last = 1'b1;
            word.error_code = ERR_OVERFLOW;
            frame_open      = 1'b0;
        end
        word.message_length = length_seen ? frame_length : '0;
        word.raw_byte_count = frame_raw;
        return word;
    endfunction

    function automatic void check_field(input string field_name, input logic [31:0] wanted,
                                        input logic [31:0] seen);
        if (seen !== wanted)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field_name, wanted, seen);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        elfr_result_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result word with none expected, byte_out %02h",
                     $time, result_if.byte_out);
            mismatch_count++;
            return;
        end
        want = awaited_results.pop_front();
        check_field("byte_out",       want.byte_out,       result_if.byte_out);
        check_field("accepted",       want.accepted,       result_if.accepted);
        check_field("frame_first",    want.frame_first,    result_if.frame_first);
        check_field("frame_last",     want.frame_last,     result_if.frame_last);
        check_field("error_code",     want.error_code,     result_if.error_code);
        check_field("message_length", want.message_length, result_if.message_length);
        check_field("raw_byte_count", want.raw_byte_count, result_if.raw_byte_count);
    endfunction

    // Result side: sample the handshake as it stood before the edge, then
    // choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            check_result();
        result_if.ready <= !(sink_stalls && $urandom_range(0, 99) < STALL_PERCENT);
    end

    // Offers one word, holds it until taken, then records what it should give.
    task automatic send_word(input logic [7:0] value);
        elfr_result_t prediction;
        while (source_stalls && $urandom_range(0, 99) < STALL_PERCENT)
        begin
            serial_if.valid <= 1'b0;
            @(posedge clk);
        end
        serial_if.valid   <= 1'b1;
        serial_if.byte_in <= value;
        do
            @(posedge clk);
        while (!serial_if.ready);
        prediction = deframe_byte(value);
        if (prediction.accepted)
            framed_words++;
        awaited_results.push_back(prediction);
    endtask

    task automatic send_words(input logic [7:0] seq [$]);
        foreach (seq[i])
            send_word(seq[i]);
    endtask

    // Sender goes quiet until every owed result word has been seen.
    // Always waits on the clock before it checks, so valid is never driven twice in a step.
    task automatic wait_results_drained();
        serial_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic set_max_frame_bytes(input logic [CFG_WIDTH-1:0] limit);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        max_frame_q  = limit;
    endtask

    // Random payload byte, never a sync; escapes now and then.
    function automatic logic [7:0] payload_byte();
        logic [7:0] rx;
        if ($urandom_range(0, 99) < 8)
            return ESC_BYTE;
        rx = 8'($urandom_range(0, 255));
        if (rx == SYNC_BYTE)
            rx = 8'hFE;
        return rx;
    endfunction

    // Mostly well-formed frames with short lengths; a few with long or
    // escaped length bytes (often cut by the limit) and a few abandoned midway.
    task automatic send_random_frame(input bit pause_inside);
        int         shape;
        int         pause_at;
        bit         long_ok;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
        shape    = $urandom_range(0, 99);
        long_ok  = (max_frame_q <= CFG_WIDTH'(LONG_CAP));
        len_hi   = 8'h00;
        len_lo   = 8'($urandom_range(0, 48));
        if (shape < 12 && long_ok)
            len_hi = 8'($urandom_range(0, 8'hFB));
        else if (shape < 24)
            len_lo = 8'($urandom_range(0, 8'hFB));
        pause_at = (pause_inside || $urandom_range(0, 29) == 0) ? 4 : 0;
        send_word(SYNC_BYTE);
        if (long_ok && $urandom_range(0, 99) < 10)
            send_word(ESC_BYTE);
        send_word(len_hi);
        if ($urandom_range(0, 99) < 10)
            send_word(ESC_BYTE);
        send_word(len_lo);
        while (frame_open)
        begin
            send_word(payload_byte());
            if (int'(frame_raw) == pause_at)
                wait_results_drained();
            if (shape >= 92 && $urandom_range(0, 99) < 10)
                break;
        end
    endtask

    task automatic send_noise();
        int count;
        count = $urandom_range(1, 6);
        repeat (count)
            send_word(8'($urandom_range(0, 255)));
    endtask

    // Reset limit of 80: stray bytes, restart, plain and escaped frames.
    task automatic test_directed_frames();
        logic [7:0] seq [$];
        seq = {8'h00, 8'hFF, ESC_BYTE,                          // stray bytes
               SYNC_BYTE, SYNC_BYTE,                            // restart in a frame
               8'h00, 8'h01, 8'hAA, 8'hBB, 8'hCC,               // length 1, completes
               SYNC_BYTE, 8'h00, 8'h00, ESC_BYTE, 8'h11, 8'h22, // escape in payload
               SYNC_BYTE, ESC_BYTE, 8'h00, ESC_BYTE, 8'h01,     // both length bytes escaped
               SYNC_BYTE, 8'h00, 8'h00, 8'h7E, 8'h80,           // length 0
               8'h55};                                          // stray after close
        send_words(seq);
        wait_results_drained();
    endtask

    // Limit extremes and the corner cases of the cut.
    task automatic test_cut_limits();
        logic [7:0] seq [$];
        set_max_frame_bytes(CFG_WIDTH'(1));      // sync byte cut on its own
        seq = {SYNC_BYTE, 8'h12};
        send_words(seq);
        set_max_frame_bytes(CFG_WIDTH'(0));
        seq = {SYNC_BYTE};
        send_words(seq);
        set_max_frame_bytes(CFG_WIDTH'(6));      // escaped length, cut
        seq = {SYNC_BYTE, ESC_BYTE, 8'h00, ESC_BYTE, 8'h01, 8'h9A};
        send_words(seq);
        set_max_frame_bytes(CFG_WIDTH'(7));      // double escape before low byte
        seq = {SYNC_BYTE, 8'h00, ESC_BYTE, ESC_BYTE, 8'h03, 8'h44, 8'h45};
        send_words(seq);
        set_max_frame_bytes(CFG_WIDTH'(5));      // completion and cut together
        seq = {SYNC_BYTE, 8'h00, 8'h00, 8'hAA, 8'hBB};
        send_words(seq);
        set_max_frame_bytes(CFG_WIDTH'(2));      // cut lands on an escape
        seq = {SYNC_BYTE, ESC_BYTE};
        send_words(seq);
        wait_results_drained();
    endtask

    // A long frame under a limit of 4096, closed by its length.
    task automatic test_longest_frame();
        set_max_frame_bytes(CFG_WIDTH'(4096));
        send_word(SYNC_BYTE);
        send_word(8'h01);
        send_word(8'hF4);
        while (frame_open)
            send_word(payload_byte());
        wait_results_drained();
    endtask

    // Phases of random traffic, each under a fresh limit. Phase 1 runs with
    // no stalls on either side.
    task automatic test_random_traffic();
        int                   phase;
        int                   phase_start;
        logic [CFG_WIDTH-1:0] limit;
        phase        = 0;
        framed_words = 0;
        while (framed_words < RANDOM_WORDS)
        begin
            if (phase == 0)
                limit = MAX_FRAME_RST;
            else
                case ($urandom_range(0, 4))
                    0:       limit = CFG_WIDTH'($urandom_range(1, 8));
                    1:       limit = CFG_WIDTH'($urandom_range(9, 64));
                    2:       limit = CFG_WIDTH'($urandom_range(65, LONG_CAP));
                    3:       limit = CFG_WIDTH'(4096);
                    default: limit = MAX_FRAME_RST;
                endcase
            set_max_frame_bytes(limit);
            source_stalls = (phase != 1);
            sink_stalls  <= (phase != 1);
            phase_start   = framed_words;
            // The first frame of phase 0 is set to pause inside until all results are back.
            if (phase == 0)
                send_random_frame(1'b1);
            while (framed_words - phase_start < PHASE_WORDS && framed_words < RANDOM_WORDS)
            begin
                if ($urandom_range(0, 99) < 80)
                    send_random_frame(1'b0);
                else
                    send_noise();
            end
            phase++;
        end
        source_stalls = 1'b1;
        sink_stalls  <= 1'b1;
        wait_results_drained();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        serial_if.valid   <= 1'b0;
        serial_if.byte_in <= 8'h00;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_cut_limits();
        test_longest_frame();
        test_random_traffic();

        // Any stray word after the last one owed is caught by the monitor.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("escaped_length_frame_receiver_core_tb: PASS");
        else
            $display("escaped_length_frame_receiver_core_tb: FAIL");
        $finish;
    end

endmodule
